// ===== src/gss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants of the Gray-Scott stencil step core.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 20;
  localparam int COEF_BITS   = 16;
  localparam int SIZE_BITS   = 8;
  localparam int CFG_IDX_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_U = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_V = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam logic [COEF_BITS-1:0] FEED_RST   = 16'd2621;
  localparam logic [COEF_BITS-1:0] KILL_RST   = 16'd3981;
  localparam logic [COEF_BITS-1:0] DIFF_U_RST = 16'd3277;
  localparam logic [COEF_BITS-1:0] DIFF_V_RST = 16'd6554;
  localparam logic [COEF_BITS-1:0] DT_RST     = 16'd13107;
  localparam logic [SIZE_BITS-1:0] SIZE_RST   = 8'd128;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] u_in;
    logic signed [SAMPLE_BITS-1:0] v_in;
    logic                          tile_start;
  } cell_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] u_out;
    logic signed [SAMPLE_BITS-1:0] v_out;
    logic                          tile_last;
  } result_t;

endpackage

// ===== src/gray_scott_stencil_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_scott_stencil_step_core
// One explicit Euler Gray-Scott step over a streamed, halo-padded tile.
// ----------------------------------------------------------------------------
// Cells of a (W+2) x (H+2) padded tile come in raster order, one request per
// clock, tile_start on padded cell (0,0). For each interior cell one updated
// (u,v) pair leaves the core once the cell below it has arrived, in raster
// order, with tile_last on the last one. Throughput is one cell per clock
// while the output does not stall. The multiplier chain (u*u, then *v,
// then *dt) has each multiply followed by a register. Two padded rows per
// field sit in two block memories split by row parity, one read and one
// write port each; the left/center neighbors come from a two-deep tap line
// fed by the read stream, column 0 of each row from a small register. A
// stall at the output freezes the whole pipe and drops cell_ready.
// ----------------------------------------------------------------------------
module gray_scott_stencil_step_core
  import gss_pkg::*;
#(
  parameter int MAX_TILE = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cell_valid,
  output logic                 cell_ready,
  input  cell_t                grid_cell,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_BITS-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PITCH = MAX_TILE + 2;
  localparam int AW    = $clog2(PITCH);
  localparam int EW    = (AW + 1 > SIZE_BITS + 1) ? AW + 1 : SIZE_BITS + 1;
  localparam int LAP_W = SB + 3;
  localparam int UU_W  = 2 * SB;
  localparam int SQ_W  = 33;
  localparam int CF_W  = COEF_BITS + 1;
  localparam int DL_W  = CF_W + LAP_W;
  localparam int FK_W  = CF_W + 1 + SB;
  localparam int OV_W  = SB + 2;
  localparam int FV_W  = CF_W + OV_W;
  localparam int UV_W  = SQ_W + SB;
  localparam int DW    = SB + 16;
  localparam int PD_W  = DW + CF_W;
  localparam int NW    = PD_W - COEF_BITS + 1;

  localparam logic signed [UU_W:0]  HALF_UU = (UU_W+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [UV_W:0]  HALF_UV = (UV_W+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [DL_W:0]  HALF_DL = (DL_W+1)'(1) <<< (COEF_BITS - 1);
  localparam logic signed [FK_W:0]  HALF_FK = (FK_W+1)'(1) <<< (COEF_BITS - 1);
  localparam logic signed [FV_W:0]  HALF_FV = (FV_W+1)'(1) <<< (COEF_BITS - 1);
  localparam logic signed [PD_W:0]  HALF_PD = (PD_W+1)'(1) <<< (COEF_BITS - 1);
  localparam logic signed [UU_W:0]  SQ_CAP  = (UU_W+1)'(1) <<< 31;
  localparam logic signed [OV_W-1:0] ONE_Q  = OV_W'(1) <<< FRAC_BITS;
  localparam logic signed [NW-1:0]  SAT_HI  = NW'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [NW-1:0]  SAT_LO  = -SAT_HI - NW'(1);

  // ---------------- configuration ----------------
  logic [COEF_BITS-1:0] feed_rate, kill_rate, diffusion_u, diffusion_v, time_step;
  logic [SIZE_BITS-1:0] tile_width, tile_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_rate   <= FEED_RST;
      kill_rate   <= KILL_RST;
      diffusion_u <= DIFF_U_RST;
      diffusion_v <= DIFF_V_RST;
      time_step   <= DT_RST;
      tile_width  <= SIZE_RST;
      tile_height <= SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FEED:   feed_rate   <= cfg_data;
        REG_KILL:   kill_rate   <= cfg_data;
        REG_DIFF_U: diffusion_u <= cfg_data;
        REG_DIFF_V: diffusion_v <= cfg_data;
        REG_DT:     time_step   <= cfg_data;
        REG_WIDTH:  tile_width  <= cfg_data[SIZE_BITS-1:0];
        REG_HEIGHT: tile_height <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Tile sizes clamped to 1..MAX_TILE.
  logic [EW-1:0] w_eff, h_eff;
  always_comb begin
    if (tile_width == '0) w_eff = EW'(1);
    else if (EW'(tile_width) > EW'(MAX_TILE)) w_eff = EW'(MAX_TILE);
    else w_eff = EW'(tile_width);
    if (tile_height == '0) h_eff = EW'(1);
    else if (EW'(tile_height) > EW'(MAX_TILE)) h_eff = EW'(MAX_TILE);
    else h_eff = EW'(tile_height);
  end

  // ---------------- global pipe enable ----------------
  // Every stage moves together; only a held result stops it.
  logic en, accept;
  assign en         = !result_valid || result_ready;
  assign cell_ready = en;
  assign accept     = cell_valid && en;

  // ---------------- stage 0: position and line stores ----------------
  logic [AW-1:0] column_count, row_count;
  logic [AW-1:0] col, row;
  logic [EW-1:0] col_e, row_e;
  logic          is_result, is_last;
  logic [AW:0]   col_plus;
  logic [AW-1:0] right_addr;

  always_comb begin
    col   = grid_cell.tile_start ? '0 : column_count;
    row   = grid_cell.tile_start ? '0 : row_count;
    col_e = EW'(col);
    row_e = EW'(row);
    is_result = (row_e >= EW'(2)) && (col_e >= EW'(1)) && (col_e <= w_eff);
    is_last   = (row_e == h_eff + EW'(1)) && (col_e == w_eff);
    col_plus  = {1'b0, col} + (AW+1)'(1);
    right_addr = (col_plus >= (AW+1)'(PITCH)) ? AW'(PITCH - 1) : col_plus[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_e + EW'(1) >= w_eff + EW'(2)) begin
        column_count <= '0;
        row_count    <= (row_e + EW'(1) >= h_eff + EW'(2)) ? '0 : row + AW'(1);
      end else begin
        column_count <= col + AW'(1);
      end
    end
  end

  // Row stores by parity: {u,v} per entry. The current row's store is read
  // at this column (the cell two rows up) and then overwritten; the other
  // store is read one column ahead (right neighbor of the center).
  logic [2*SB-1:0] mem_even [PITCH];
  logic [2*SB-1:0] mem_odd  [PITCH];
  logic [2*SB-1:0] rd_even, rd_odd;
  logic [AW-1:0]   addr_even, addr_odd;

  assign addr_even = row[0] ? right_addr : col;
  assign addr_odd  = row[0] ? col : right_addr;

  always_ff @(posedge clk) begin
    if (en) rd_even <= mem_even[addr_even];
    if (accept && !row[0]) mem_even[col] <= {grid_cell.u_in, grid_cell.v_in};
  end

  always_ff @(posedge clk) begin
    if (en) rd_odd <= mem_odd[addr_odd];
    if (accept && row[0]) mem_odd[col] <= {grid_cell.u_in, grid_cell.v_in};
  end

  // Column 0 of each parity, the left neighbor of the first interior cell.
  logic [2*SB-1:0] col0 [2];
  always_ff @(posedge clk) begin
    if (accept && col == '0) col0[row[0]] <= {grid_cell.u_in, grid_cell.v_in};
  end

  // ---------------- stage 1: window ----------------
  logic            s1_valid, s1_res, s1_last, s1_first, s1_par;
  logic [2*SB-1:0] s1_down, s1_col0;
  logic [2*SB-1:0] tap1, tap2;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_res   <= is_result;
      s1_last  <= is_last;
      s1_first <= (col == AW'(1));
      s1_par   <= row[0];
      s1_down  <= {grid_cell.u_in, grid_cell.v_in};
      s1_col0  <= col0[~row[0]];
    end
  end

  logic [2*SB-1:0] w_right, w_up, w_center, w_left;
  assign w_right  = s1_par ? rd_even : rd_odd;
  assign w_up     = s1_par ? rd_odd : rd_even;
  assign w_center = tap1;
  assign w_left   = s1_first ? s1_col0 : tap2;

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      tap1 <= w_right;
      tap2 <= tap1;
    end
  end

  logic signed [SB-1:0] lu, ru, uu_c, upu, dnu, lv, rv, vv_c, upv, dnv;
  assign {lu, lv}     = w_left;
  assign {ru, rv}     = w_right;
  assign {uu_c, vv_c} = w_center;
  assign {upu, upv}   = w_up;
  assign {dnu, dnv}   = s1_down;

  // ---------------- stage 2: Laplacian, u*u ----------------
  logic                    s2_valid, s2_last;
  logic signed [LAP_W-1:0] s2_lap_u, s2_lap_v;
  logic signed [SB-1:0]    s2_u, s2_v;
  logic signed [UU_W-1:0]  s2_uu;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid && s1_res;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last  <= s1_last;
      s2_u     <= uu_c;
      s2_v     <= vv_c;
      s2_lap_u <= LAP_W'(lu) + LAP_W'(ru) + LAP_W'(upu) + LAP_W'(dnu)
                  - (LAP_W'(uu_c) <<< 2);
      s2_lap_v <= LAP_W'(lv) + LAP_W'(rv) + LAP_W'(upv) + LAP_W'(dnv)
                  - (LAP_W'(vv_c) <<< 2);
      s2_uu    <= UU_W'(uu_c) * UU_W'(uu_c);
    end
  end

  // ---------------- stage 3: coefficient products ----------------
  // F+k needs one bit more than a single coefficient
  logic signed [CF_W:0]   fk_s;
  logic signed [CF_W-1:0] f_s, du_s, dv_s, dt_s;
  assign fk_s = (CF_W+1)'(feed_rate) + (CF_W+1)'(kill_rate);
  assign f_s  = {1'b0, feed_rate};
  assign du_s = {1'b0, diffusion_u};
  assign dv_s = {1'b0, diffusion_v};
  assign dt_s = {1'b0, time_step};

  logic signed [UU_W:0] sq_full;
  always_comb begin
    sq_full = (UU_W+1)'(s2_uu) + HALF_UU;
    sq_full = sq_full >>> FRAC_BITS;
    if (sq_full > SQ_CAP) sq_full = SQ_CAP;
  end

  logic                   s3_valid, s3_last;
  logic signed [SB-1:0]   s3_u, s3_v;
  logic signed [SQ_W-1:0] s3_sq;
  logic signed [DL_W-1:0] s3_dlu, s3_dlv;
  logic signed [FK_W-1:0] s3_fk;
  logic signed [FV_W-1:0] s3_fv;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_last;
      s3_u    <= s2_u;
      s3_v    <= s2_v;
      s3_sq   <= sq_full[SQ_W-1:0];
      s3_dlu  <= DL_W'(du_s) * DL_W'(s2_lap_u);
      s3_dlv  <= DL_W'(dv_s) * DL_W'(s2_lap_v);
      s3_fk   <= FK_W'(fk_s) * FK_W'(s2_u);
      s3_fv   <= FV_W'(f_s) * FV_W'(ONE_Q - OV_W'(s2_v));
    end
  end

  // ---------------- stage 4: u*u*v, linear terms ----------------
  logic signed [DL_W:0] dlu_r, dlv_r;
  logic signed [FK_W:0] fk_r;
  logic signed [FV_W:0] fv_r;
  always_comb begin
    dlu_r = ((DL_W+1)'(s3_dlu) + HALF_DL) >>> COEF_BITS;
    dlv_r = ((DL_W+1)'(s3_dlv) + HALF_DL) >>> COEF_BITS;
    fk_r  = ((FK_W+1)'(s3_fk) + HALF_FK) >>> COEF_BITS;
    fv_r  = ((FV_W+1)'(s3_fv) + HALF_FV) >>> COEF_BITS;
  end

  logic                   s4_valid, s4_last;
  logic signed [SB-1:0]   s4_u, s4_v;
  logic signed [UV_W-1:0] s4_uuv;
  logic signed [DW-1:0]   s4_pu, s4_pv;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_last <= s3_last;
      s4_u    <= s3_u;
      s4_v    <= s3_v;
      s4_uuv  <= UV_W'(s3_sq) * UV_W'(s3_v);
      s4_pu   <= DW'(dlu_r) - DW'(fk_r);
      s4_pv   <= DW'(dlv_r) + DW'(fv_r);
    end
  end

  // ---------------- stage 5: du, dv ----------------
  logic signed [UV_W:0] uuv_r;
  assign uuv_r = ((UV_W+1)'(s4_uuv) + HALF_UV) >>> FRAC_BITS;

  logic                 s5_valid, s5_last;
  logic signed [SB-1:0] s5_u, s5_v;
  logic signed [DW-1:0] s5_du, s5_dv;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (en) s5_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_last <= s4_last;
      s5_u    <= s4_u;
      s5_v    <= s4_v;
      s5_du   <= s4_pu + DW'(uuv_r);
      s5_dv   <= s4_pv - DW'(uuv_r);
    end
  end

  // ---------------- stage 6: times dt ----------------
  logic                   s6_valid, s6_last;
  logic signed [SB-1:0]   s6_u, s6_v;
  logic signed [PD_W-1:0] s6_mu, s6_mv;

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else if (en) s6_valid <= s5_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_last <= s5_last;
      s6_u    <= s5_u;
      s6_v    <= s5_v;
      s6_mu   <= PD_W'(s5_du) * PD_W'(dt_s);
      s6_mv   <= PD_W'(s5_dv) * PD_W'(dt_s);
    end
  end

  // ---------------- output register: add and saturate ----------------
  logic signed [PD_W:0] mu_r, mv_r;
  logic signed [NW-1:0] nu, nv;
  logic signed [SB-1:0] su, sv;
  always_comb begin
    mu_r = ((PD_W+1)'(s6_mu) + HALF_PD) >>> COEF_BITS;
    mv_r = ((PD_W+1)'(s6_mv) + HALF_PD) >>> COEF_BITS;
    nu   = NW'(s6_u) + NW'(mu_r);
    nv   = NW'(s6_v) + NW'(mv_r);
    if (nu > SAT_HI) su = SAT_HI[SB-1:0];
    else if (nu < SAT_LO) su = SAT_LO[SB-1:0];
    else su = nu[SB-1:0];
    if (nv > SAT_HI) sv = SAT_HI[SB-1:0];
    else if (nv < SAT_LO) sv = SAT_LO[SB-1:0];
    else sv = nv[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= s6_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.u_out     <= su;
      result.v_out     <= sv;
      result.tile_last <= s6_last;
    end
  end

endmodule

// ===== src/gss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks for the Gray-Scott stencil step core.
// ----------------------------------------------------------------------------
module gss_checker
  import gss_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    cell_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result,
  input logic    cfg_ready
);

  // held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a stalled result blocks new requests
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !cell_ready)
    else $error("request taken during output stall");

  // pipe is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind gray_scott_stencil_step_core gss_checker u_gss_checker (
  .clk          (clk),
  .rst          (rst),
  .cell_ready   (cell_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_ready    (cfg_ready)
);
